FILE: rtl/core/tmcw_pkg.sv
// Shared types, constants and helpers for the text mode console writer.
// Depends on nothing; tmcw_ctrl and the top level in rtl/core use it by scoped names.
package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W       = $clog2(CELLS);

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int COLOR_W = 4;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;
    localparam logic [COLOR_W-1:0]   FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0]   BG_RESET = 4'h0;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

    // Content of every cell after reset: space, white on black
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

FILE: rtl/core/tmcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the screen cell store.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tmcw_ctrl.sv
// Sequencer of the console writer: cursor, item decode and the cell sweep
// counter that drives copy, fill and clear passes over the cell RAM.
// Depends on tmcw_pkg.
module tmcw_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tmcw_pkg::t_item              i_item,
    input  logic [tmcw_pkg::ATTR_W-1:0]  i_attr,
    output tmcw_pkg::t_mem_req           o_mem,
    input  logic [tmcw_pkg::CELL_W-1:0]  i_rd_data,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output tmcw_pkg::t_result            o_res
);

    tmcw_pkg::t_state                 r_state, n_state;
    tmcw_pkg::t_item                  r_item, n_item;
    logic [tmcw_pkg::ROW_W-1:0]       r_row, n_row;
    logic [tmcw_pkg::COL_W-1:0]       r_col, n_col;
    logic [tmcw_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [tmcw_pkg::CELL_W-1:0]      r_cell, n_cell;
    logic                             r_scrolled, n_scrolled;
    logic [tmcw_pkg::CELL_W-1:0]      blank;
    logic                             last_row;
    logic                             read_ok;

    assign blank    = {i_attr, tmcw_pkg::BLANK_CHAR};
    assign last_row = (r_row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
    assign read_ok  = (int'(r_item.read_row) < tmcw_pkg::ROWS) &&
                      (int'(r_item.read_col) < tmcw_pkg::COLUMNS);

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmcw_pkg::ST_INIT;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
            r_cell     <= '0;
            r_scrolled <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_addr     <= n_addr;
            r_cell     <= n_cell;
            r_scrolled <= n_scrolled;
        end
        r_item <= n_item;
    end

    // Next state, cursor update and RAM requests
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_cell     = r_cell;
        n_scrolled = r_scrolled;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_addr;
        o_mem.wdata = blank;
        o_mem.raddr = r_addr;

        case (r_state)
            tmcw_pkg::ST_INIT: begin
                // Sweep the reset pattern into every cell
                o_mem.we    = 1'b1;
                o_mem.wdata = tmcw_pkg::RESET_CELL;
                if (r_addr == tmcw_pkg::ADDR_W'(tmcw_pkg::CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = tmcw_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + tmcw_pkg::ADDR_W'(1);
                end
            end

            tmcw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_item;
                    n_state = tmcw_pkg::ST_EXEC;
                end
            end

            tmcw_pkg::ST_EXEC: begin
                n_cell     = '0;
                n_scrolled = 1'b0;
                n_addr     = '0;
                n_state    = tmcw_pkg::ST_DONE;
                case (r_item.mode)
                    tmcw_pkg::MODE_PUT: begin
                        case (r_item.char_code)
                            tmcw_pkg::CH_NEWLINE: begin
                                n_col = '0;
                                if (last_row) begin
                                    n_scrolled = 1'b1;
                                    n_state    = tmcw_pkg::ST_COPY;
                                end else begin
                                    n_row = r_row + tmcw_pkg::ROW_W'(1);
                                end
                            end
                            tmcw_pkg::CH_RETURN: begin
                                n_col = '0;
                            end
                            tmcw_pkg::CH_BACKSPACE: begin
                                // Step left and blank, unless at the left edge
                                if (r_col != '0) begin
                                    n_col       = r_col - tmcw_pkg::COL_W'(1);
                                    o_mem.we    = 1'b1;
                                    o_mem.waddr = tmcw_pkg::cell_addr(r_row,
                                                      r_col - tmcw_pkg::COL_W'(1));
                                    o_mem.wdata = blank;
                                end
                            end
                            default: begin
                                // Store the character and advance, wrapping at the edge
                                o_mem.we    = 1'b1;
                                o_mem.waddr = tmcw_pkg::cell_addr(r_row, r_col);
                                o_mem.wdata = {i_attr, r_item.char_code};
                                if (r_col == tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1)) begin
                                    n_col = '0;
                                    if (last_row) begin
                                        n_scrolled = 1'b1;
                                        n_state    = tmcw_pkg::ST_COPY;
                                    end else begin
                                        n_row = r_row + tmcw_pkg::ROW_W'(1);
                                    end
                                end else begin
                                    n_col = r_col + tmcw_pkg::COL_W'(1);
                                end
                            end
                        endcase
                    end
                    tmcw_pkg::MODE_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = tmcw_pkg::ST_FILL;
                    end
                    tmcw_pkg::MODE_READ: begin
                        if (read_ok) begin
                            o_mem.raddr = tmcw_pkg::cell_addr(r_item.read_row,
                                                              r_item.read_col);
                            n_state     = tmcw_pkg::ST_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = tmcw_pkg::ST_DONE;
                    end
                endcase
            end

            tmcw_pkg::ST_RDWAIT: begin
                n_cell  = i_rd_data;
                n_state = tmcw_pkg::ST_DONE;
            end

            tmcw_pkg::ST_COPY: begin
                // Read the cell one row below, write the previous read one step back
                if (r_addr != tmcw_pkg::ADDR_W'(tmcw_pkg::SCROLL_CELLS)) begin
                    o_mem.raddr = r_addr + tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS);
                end
                o_mem.we    = (r_addr != '0);
                o_mem.waddr = r_addr - tmcw_pkg::ADDR_W'(1);
                o_mem.wdata = i_rd_data;
                if (r_addr == tmcw_pkg::ADDR_W'(tmcw_pkg::SCROLL_CELLS)) begin
                    n_state = tmcw_pkg::ST_FILL;
                end else begin
                    n_addr = r_addr + tmcw_pkg::ADDR_W'(1);
                end
            end

            tmcw_pkg::ST_FILL: begin
                // Blank cells up to the end of the screen
                o_mem.we    = 1'b1;
                o_mem.wdata = blank;
                if (r_addr == tmcw_pkg::ADDR_W'(tmcw_pkg::CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = tmcw_pkg::ST_DONE;
                end else begin
                    n_addr = r_addr + tmcw_pkg::ADDR_W'(1);
                end
            end

            tmcw_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = tmcw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.cursor_row = r_row;
    assign o_res.cursor_col = r_col;
    assign o_res.cell_value = r_cell;
    assign o_res.scrolled   = r_scrolled;

endmodule

FILE: rtl/core/text_mode_console_writer_unit.sv
// Text mode console writer top level: color registers, cell RAM, sequencer
// and the result register. Depends on tmcw_pkg, tmcw_ram and tmcw_ctrl.
//
// An 80 by 25 screen of 16-bit cells (attribute high byte, character low
// byte) with a cursor. After reset the block runs a clearing pass that
// writes space, white on black, to every cell; o_in_ready stays low
// meanwhile, while color writes on the configuration port are taken at
// any time. Every item is handled by one sequencer stepping a single cell
// counter against the one write and one read port of the cell RAM, one cell
// per cycle, and the block takes no new item until it has finished. Items
// other than in-range reads, clears and scrolls go straight from execute
// to the result; a read passes through a wait state, a clear blanks every
// cell, and a put or newline that scrolls copies the screen up one row and
// blanks the bottom row. The result sits in an output register, so the
// next item is accepted while it waits to be taken.
module text_mode_console_writer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [tmcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tmcw_pkg::ROW_W-1:0]      i_read_row,
    input  logic [tmcw_pkg::COL_W-1:0]      i_read_col,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tmcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]      o_cursor_col,
    output logic [tmcw_pkg::CELL_W-1:0]     o_cell_value,
    output logic                            o_scrolled,
    // Configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmcw_pkg::COLOR_W-1:0]    i_cfg_data
);

    logic [tmcw_pkg::COLOR_W-1:0] r_fg;
    logic [tmcw_pkg::COLOR_W-1:0] r_bg;
    tmcw_pkg::t_item              item;
    tmcw_pkg::t_mem_req           mem;
    logic [tmcw_pkg::CELL_W-1:0]  rd_data;
    logic                         res_valid;
    logic                         res_ready;
    tmcw_pkg::t_result            res;
    logic                         r_out_valid;
    tmcw_pkg::t_result            r_out;

    // Color registers, written on a config beat
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tmcw_pkg::FG_RESET;
            r_bg <= tmcw_pkg::BG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tmcw_pkg::CFG_FOREGROUND) begin
                r_fg <= i_cfg_data;
            end
            if (i_cfg_index == tmcw_pkg::CFG_BACKGROUND) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    assign item.mode      = tmcw_pkg::t_mode'(i_mode);
    assign item.char_code = i_char_code;
    assign item.read_row  = i_read_row;
    assign item.read_col  = i_read_col;

    tmcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (item),
        .i_attr      ({r_bg, r_fg}),
        .o_mem       (mem),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    tmcw_ram #(
        .WIDTH (tmcw_pkg::CELL_W),
        .DEPTH (tmcw_pkg::CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    // Result register: load when empty or draining, drop on an output beat
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_out.cursor_row;
    assign o_cursor_col = r_out.cursor_col;
    assign o_cell_value = r_out.cell_value;
    assign o_scrolled   = r_out.scrolled;

    // One item at a time: the sequencer is busy right after a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // A scroll always leaves the cursor on the bottom row at column 0
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |->
            (o_cursor_row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1)) && (o_cursor_col == '0))
        else $error("scroll result with cursor off the bottom row start");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (int'(o_cursor_row) < tmcw_pkg::ROWS) && (int'(o_cursor_col) < tmcw_pkg::COLUMNS))
        else $error("cursor outside the screen");

endmodule
